// ===== sv/sorted_key_table_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_key_table_macros
// assertion helpers shared by the sorted key table rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SKT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_table check failed");

// next-cycle implication, checked out of reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_table check failed");

`endif

// ===== sv/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// shared widths, operation codes and cell command type
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_W   = 32;
  localparam int OP_W    = 2;
  localparam int ENTRY_W = 7;
  localparam int OR_GROUP = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic signed [KEY_W-1:0] key;
  } skt_cmd_t;

endpackage

// ===== sv/skt_if.sv =====
// ----------------------------------------------------------------------------
// skt_if
// valid/ready channels for the sorted key table items and results
// ----------------------------------------------------------------------------
interface skt_in_if;
  import skt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface skt_out_if;
  import skt_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [ENTRY_W-1:0] entry_count;
  logic               full_reject;

  modport source (output valid, output found, output entry_count, output full_reject,
                  input ready);
  modport sink   (input valid, input found, input entry_count, input full_reject,
                  output ready);
endinterface

// ===== sv/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table
// bounded table of signed keys held in ascending order in a row of cells
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per valid/ready handshake: operation (insert,
//   search, clear; the fourth code is a no-op) and a signed 32-bit key.
//   out_ch returns exactly one result per item, in order: found (search
//   hit), entry_count (keys stored after the item, low 7 bits) and
//   full_reject (insert dropped because all CAPACITY slots were taken).
//   An insert or clear updates the cell row at the accept edge, so the
//   next item already sees it. A search registers one match bit per cell,
//   ors them in groups of eight in the next stage, and the final or feeds
//   the output register.
//   Throughput: one item per cycle if out_ch does not stall; the cell row
//   does every compare and shift in parallel, and the three-stage result
//   path (stage one, stage two, output register) is fully pipelined.
//   Reset empties the table (fill count to zero) and drops items in flight;
//   no clearing pass is needed.
//   When out_ch stalls, the result holds in the output register and the
//   two earlier stages keep filling; in_ch.ready falls once all are full.
// ----------------------------------------------------------------------------
`include "sorted_key_table_macros.svh"

module sorted_key_table #(
  parameter int CAPACITY = 64
) (
  input logic       clk,
  input logic       rst_n,
  skt_in_if.sink    in_ch,
  skt_out_if.source out_ch
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + OR_GROUP - 1) / OR_GROUP;

  logic                    accept;
  logic                    is_insert;
  logic                    is_search;
  logic                    is_clear;
  logic                    full;
  skt_cmd_t                cmd;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W+ENTRY_W-1:0] count_ext;

  logic                    ge_w  [CAPACITY];
  logic signed [KEY_W-1:0] key_w [CAPACITY];
  logic [CAPACITY-1:0]     match_w;

  logic                    s1_v_r;
  logic                    s1_srch_r;
  logic                    s1_rej_r;
  logic [ENTRY_W-1:0]      s1_cnt_r;
  logic [CAPACITY-1:0]     s1_match_r;

  logic                    s2_load;
  logic                    s2_v_r;
  logic                    s2_srch_r;
  logic                    s2_rej_r;
  logic [ENTRY_W-1:0]      s2_cnt_r;
  logic [NGRP-1:0]         grp_r;

  logic                    out_load;
  logic                    out_v_r;
  logic                    out_found_r;
  logic                    out_srch_r;
  logic                    out_rej_r;
  logic [ENTRY_W-1:0]      out_cnt_r;

  // decode the incoming item
  assign accept    = in_ch.valid && in_ch.ready;
  assign is_insert = (in_ch.operation == OP_INSERT);
  assign is_search = (in_ch.operation == OP_SEARCH);
  assign is_clear  = (in_ch.operation == OP_CLEAR);
  assign full      = (count_r == CNT_W'(CAPACITY));

  assign cmd.ins = accept && is_insert && !full;
  assign cmd.key = in_ch.key;

  // stage handshakes, each stage moves when the one after it has room
  assign out_load    = s2_v_r && (!out_v_r || out_ch.ready);
  assign s2_load     = s1_v_r && (!s2_v_r || out_load);
  assign in_ch.ready = !s1_v_r || s2_load;

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (accept && is_clear) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // reported count is the low bits of the fill count after the item
  assign count_ext = {{ENTRY_W{1'b0}}, count_nxt};

  // row of cells, each passing its key and insertion flag to the right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      skt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .count    (count_r),
        .left_ge  (1'b0),
        .left_key (cmd.key),
        .ge       (ge_w[i]),
        .key_r    (key_w[i]),
        .match    (match_w[i])
      );
    end else begin : g_body
      skt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .count    (count_r),
        .left_ge  (ge_w[i-1]),
        .left_key (key_w[i-1]),
        .ge       (ge_w[i]),
        .key_r    (key_w[i]),
        .match    (match_w[i])
      );
    end
  end

  // stage one: per-cell match bits and item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s2_load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_srch_r  <= is_search;
      s1_rej_r   <= is_insert && full;
      s1_cnt_r   <= count_ext[ENTRY_W-1:0];
      s1_match_r <= match_w;
    end
  end

  // stage two: group ors
  skt_or_tree #(.N(CAPACITY), .GROUP(OR_GROUP)) u_or_tree (
    .clk   (clk),
    .load  (s2_load),
    .match (s1_match_r),
    .grp_r (grp_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= 1'b1;
    end else if (out_load) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_srch_r <= s1_srch_r;
      s2_rej_r  <= s1_rej_r;
      s2_cnt_r  <= s1_cnt_r;
    end
  end

  // output register: final or of the groups
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= s2_srch_r && (|grp_r);
      out_srch_r  <= s2_srch_r;
      out_rej_r   <= s2_rej_r;
      out_cnt_r   <= s2_cnt_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.full_reject = out_rej_r;

  // checks
  `SKT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SKT_ASSERT_NEXT(a_clear_empties, accept && is_clear, count_r == '0)
  `SKT_ASSERT_NOW(a_found_on_search, out_v_r && out_found_r, out_srch_r && !out_rej_r)

endmodule

// ===== sv/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell
// one slot of the sorted key row: compares, matches and shifts right on insert
// ----------------------------------------------------------------------------
module skt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                            clk,
  input  skt_pkg::skt_cmd_t               cmd,
  input  logic [CNT_W-1:0]                count,
  input  logic                            left_ge,
  input  logic signed [skt_pkg::KEY_W-1:0] left_key,
  output logic                            ge,
  output logic signed [skt_pkg::KEY_W-1:0] key_r,
  output logic                            match
);
  import skt_pkg::*;

  logic occupied;

  // slot holds a live key when it sits below the fill count
  assign occupied = (CNT_W'(IDX) < count);

  // at or past the insertion point: empty, or stored key not below the new one
  assign ge    = !occupied || !($signed(key_r) < $signed(cmd.key));
  assign match = occupied && (key_r == cmd.key);

  // first slot at the insertion point takes the new key, later ones take the left key
  always_ff @(posedge clk) begin
    if (cmd.ins && ge) begin
      key_r <= left_ge ? left_key : cmd.key;
    end
  end

endmodule

// ===== sv/skt_or_tree.sv =====
// ----------------------------------------------------------------------------
// skt_or_tree
// first level of the registered match reduction, one bit per group of cells
// ----------------------------------------------------------------------------
module skt_or_tree #(
  parameter int N     = 64,
  parameter int GROUP = 8,
  localparam int NGRP = (N + GROUP - 1) / GROUP
) (
  input  logic            clk,
  input  logic            load,
  input  logic [N-1:0]    match,
  output logic [NGRP-1:0] grp_r
);
  import skt_pkg::*;

  logic [NGRP-1:0] grp_nxt;

  // or each group, the last one may be short
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = 1'b0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < N) begin
          grp_nxt[g] = grp_nxt[g] | match[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_nxt;
    end
  end

endmodule

// ===== tb/sv/tb_sorted_key_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table
// checks the sorted key table against an in-bench table model: directed
// extremes first, then random fill / search / clear rounds with random gaps
// on both channels and one long result stall
// ----------------------------------------------------------------------------
module tb_sorted_key_table;
  import skt_pkg::*;

  localparam int CAPACITY = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1350;
  localparam int MAX_GAP = 19;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] key;
  } table_item_t;

  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] entry_count;
    logic               full_reject;
  } table_result_t;

  logic clk;
  logic rst_n;

  skt_in_if  in_ch ();
  skt_out_if out_ch ();

  sorted_key_table #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  table_item_t   item_queue[$];
  table_result_t awaited_results[$];

  // model of the table contents
  logic signed [KEY_W-1:0] model_keys[CAPACITY];
  int                      model_count;

  // generator's own view of stored keys, used to aim searches at hits
  int gen_keys[$];

  int errors;
  int items_sent;
  int results_seen;
  int send_gap;
  int recv_stall;
  int recv_hold;
  int idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // work out the result of one accepted item and update the model table
  function automatic table_result_t table_predict(table_item_t it);
    table_result_t r;
    int pos;
    r = '0;
    case (it.operation)
      OP_INSERT: begin
        if (model_count >= CAPACITY) begin
          r.full_reject = 1'b1;
        end else begin
          pos = 0;
          while (pos < model_count && model_keys[pos] < it.key) pos++;
          for (int i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
          model_keys[pos] = it.key;
          model_count++;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < model_count; i++)
          if (model_keys[i] == it.key) r.found = 1'b1;
      end
      OP_CLEAR: begin
        model_count = 0;
      end
      default: ;
    endcase
    r.entry_count = ENTRY_W'(model_count);
    return r;
  endfunction

  task automatic add_item(logic [OP_W-1:0] op, int key);
    table_item_t it;
    it.operation = op;
    it.key = key;
    item_queue.push_back(it);
    if (op == OP_INSERT && gen_keys.size() < CAPACITY) gen_keys.push_back(key);
    if (op == OP_CLEAR) gen_keys.delete();
  endtask

  function automatic int draw_key(bit narrow);
    if (narrow) return int'($urandom_range(0, 15)) - 8;
    return int'($urandom);
  endfunction

  // search key: a stored one, a near miss or anything
  function automatic int search_key(bit narrow);
    int k;
    k = draw_key(narrow);
    if (gen_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
      k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
      if ($urandom_range(0, 3) == 0) k = k + 1;
    end
    return k;
  endfunction

  // one fill / search / clear round
  task automatic add_round();
    bit narrow;
    int target;
    int n;
    narrow = ($urandom_range(0, 1) == 1);
    if ($urandom_range(0, 2) == 0) target = CAPACITY + $urandom_range(1, 4);
    else target = gen_keys.size() + $urandom_range(1, 30);
    n = target - gen_keys.size();
    // inserts, with searches and noise mixed in
    for (int i = 0; i < n; i++) begin
      add_item(OP_INSERT, draw_key(narrow));
      if ($urandom_range(0, 3) == 0) add_item(OP_SEARCH, search_key(narrow));
      if ($urandom_range(0, 29) == 0) add_item(OP_UNUSED, draw_key(narrow));
    end
    n = $urandom_range(2, 10);
    for (int i = 0; i < n; i++) add_item(OP_SEARCH, search_key(narrow));
    if ($urandom_range(0, 3) != 0) add_item(OP_CLEAR, draw_key(narrow));
    if ($urandom_range(0, 9) == 0) add_item(OP_CLEAR, int'($urandom));
  endtask

  // driver: presents queued items, gap drawn per item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_results.push_back(table_predict('{in_ch.operation, in_ch.key}));
        items_sent++;
        // every third block of items goes without gaps
        if ((items_sent / 80) % 3 == 1) send_gap = 0;
        else send_gap = $urandom_range(0, MAX_GAP);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the current item
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (item_queue.size() > 0) begin
        table_item_t it;
        it = item_queue.pop_front();
        in_ch.operation <= it.operation;
        in_ch.key       <= it.key;
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: checks results in order, stalls at random and once for long
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
      recv_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        table_result_t exp_r;
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: found %0b entry_count %0d full_reject %0b",
                 out_ch.found, out_ch.entry_count, out_ch.full_reject);
          errors++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_ch.found !== exp_r.found) begin
            $error("found: expected %0b, got %0b", exp_r.found, out_ch.found);
            errors++;
          end
          if (out_ch.entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                   out_ch.entry_count);
            errors++;
          end
          if (out_ch.full_reject !== exp_r.full_reject) begin
            $error("full_reject: expected %0b, got %0b", exp_r.full_reject,
                   out_ch.full_reject);
            errors++;
          end
        end
        if ((results_seen / 64) % 3 == 0) recv_stall = 0;
        else recv_stall = $urandom_range(0, MAX_GAP);
        if (results_seen == HOLD_AT) recv_hold = HOLD_CYCLES;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    model_count = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.key = '0;
    out_ch.ready = 1'b0;

    // directed: key extremes, duplicates, hits and misses, unused code, clear
    add_item(OP_SEARCH, 0);
    add_item(OP_CLEAR, 0);
    add_item(OP_INSERT, 0);
    add_item(OP_INSERT, 32'h7fff_ffff);
    add_item(OP_INSERT, 32'h8000_0000);
    add_item(OP_INSERT, -1);
    add_item(OP_INSERT, 32'h7fff_ffff);
    add_item(OP_INSERT, 1);
    add_item(OP_SEARCH, 32'h8000_0000);
    add_item(OP_SEARCH, 32'h7fff_ffff);
    add_item(OP_SEARCH, -1);
    add_item(OP_SEARCH, 2);
    add_item(OP_SEARCH, 32'h7fff_fffe);
    add_item(OP_SEARCH, 32'h8000_0001);
    add_item(OP_UNUSED, 2);
    add_item(OP_UNUSED, 32'h7fff_ffff);
    add_item(OP_SEARCH, 0);
    add_item(OP_CLEAR, -1);
    add_item(OP_SEARCH, 32'h7fff_ffff);
    add_item(OP_INSERT, 32'h5555_aaaa);
    add_item(OP_SEARCH, 32'h5555_aaaa);
    add_item(OP_CLEAR, 32'haaaa_5555);

    // random rounds
    while (item_queue.size() < RANDOM_ITEMS) add_round();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // wait until every item went in and every result came back
    do @(negedge clk);
    while (item_queue.size() > 0 || in_ch.valid || awaited_results.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
